FILE: src/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, codes and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Default size of the character-cell store, in cells (a power of two)
  localparam int TCW_VIDEO_WORDS = 16384;

  // Width of cursor and origin positions; holds every reachable position
  localparam int CPOS_W = 18;

  // Configuration port address width: five registers at 4-byte spacing
  localparam int CFG_ADDR_W = 5;

  typedef enum logic [1:0] {
    REQ_PUT  = 2'd0,
    REQ_READ = 2'd1,
    REQ_MOVE = 2'd2,
    REQ_NONE = 2'd3
  } tcw_req_t;

  typedef enum logic [2:0] {
    REG_NUM_COLUMNS  = 3'd0,
    REG_NUM_LINES    = 3'd1,
    REG_WINDOW_WORDS = 3'd2,
    REG_ERASE_CELL   = 3'd3,
    REG_TEXT_ATTR    = 3'd4
  } tcw_reg_t;

  // Register reset values
  localparam logic [7:0]  RST_NUM_COLUMNS  = 8'd80;
  localparam logic [7:0]  RST_NUM_LINES    = 8'd25;
  localparam logic [14:0] RST_WINDOW_WORDS = 15'd16384;
  localparam logic [15:0] RST_ERASE_CELL   = 16'h0720;
  localparam logic [7:0]  RST_TEXT_ATTR    = 8'h07;

  // Character codes
  localparam logic [7:0] CH_BS        = 8'd8;
  localparam logic [7:0] CH_LF        = 8'd10;
  localparam logic [7:0] CH_VT        = 8'd11;
  localparam logic [7:0] CH_FF        = 8'd12;
  localparam logic [7:0] CH_CR        = 8'd13;
  localparam logic [7:0] CH_PRINT_LO  = 8'd32;
  localparam logic [7:0] CH_PRINT_HI  = 8'd126;
  localparam logic [7:0] CH_DEL       = 8'd127;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_LF,
    ST_COPY,
    ST_BLANK,
    ST_LFEND,
    ST_WRITE,
    ST_POST,
    ST_PMUL,
    ST_PLACE,
    ST_RDWAIT,
    ST_DONE
  } tcw_state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  char_code;
    logic        end_of_text;
    logic [13:0] cell_index;
    logic [7:0]  new_col;
    logic [7:0]  new_row;
  } tcw_in_t;

  typedef struct packed {
    logic [15:0] read_cell;
    logic [14:0] cursor_offset;
    logic [13:0] origin_offset;
    logic [7:0]  cursor_col;
    logic [7:0]  cursor_row;
  } tcw_out_t;

  typedef struct packed {
    logic [7:0]  num_columns;
    logic [7:0]  num_lines;
    logic [14:0] window_words;
    logic [15:0] erase_cell;
    logic [7:0]  text_attr;
  } tcw_cfg_t;

endpackage
`default_nettype wire

FILE: src/tcw_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_regs
// Configuration register bank behind an APB-style port.
// ----------------------------------------------------------------------------
module tcw_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tcw_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  output tcw_pkg::tcw_cfg_t                    cfg
);
  import tcw_pkg::*;

  tcw_cfg_t cfg_r;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_columns  <= RST_NUM_COLUMNS;
      cfg_r.num_lines    <= RST_NUM_LINES;
      cfg_r.window_words <= RST_WINDOW_WORDS;
      cfg_r.erase_cell   <= RST_ERASE_CELL;
      cfg_r.text_attr    <= RST_TEXT_ATTR;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_NUM_COLUMNS:  cfg_r.num_columns  <= pwdata[7:0];
        REG_NUM_LINES:    cfg_r.num_lines    <= pwdata[7:0];
        REG_WINDOW_WORDS: cfg_r.window_words <= pwdata[14:0];
        REG_ERASE_CELL:   cfg_r.erase_cell   <= pwdata[15:0];
        REG_TEXT_ATTR:    cfg_r.text_attr    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_NUM_COLUMNS:  prdata = 32'(cfg_r.num_columns);
      REG_NUM_LINES:    prdata = 32'(cfg_r.num_lines);
      REG_WINDOW_WORDS: prdata = 32'(cfg_r.window_words);
      REG_ERASE_CELL:   prdata = 32'(cfg_r.erase_cell);
      REG_TEXT_ATTR:    prdata = 32'(cfg_r.text_attr);
      default:          prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/tcw_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_store
// Character-cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_store #(
  parameter  int DEPTH  = tcw_pkg::TCW_VIDEO_WORDS,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [15:0]       wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [15:0]       rdata
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: src/tcw_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_engine
// Cursor state, request sequencer and store access (print, scroll, read).
// ----------------------------------------------------------------------------
module tcw_engine #(
  parameter  int VIDEO_WORDS = tcw_pkg::TCW_VIDEO_WORDS,
  localparam int ADDR_W      = $clog2(VIDEO_WORDS)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tcw_pkg::tcw_cfg_t cfg,
  input  wire logic              start,
  input  wire tcw_pkg::tcw_in_t  in_req,
  output logic                   busy,
  output logic                   out_valid,
  output tcw_pkg::tcw_out_t      out_res,
  output logic                   mem_we,
  output logic [ADDR_W-1:0]      mem_waddr,
  output logic [15:0]            mem_wdata,
  output logic [ADDR_W-1:0]      mem_raddr,
  input  wire logic [15:0]       mem_rdata
);
  import tcw_pkg::*;

  localparam logic [16:0]       VW_L     = 17'(VIDEO_WORDS);
  localparam logic [ADDR_W-1:0] LAST_ADR = ADDR_W'(VIDEO_WORDS - 1);

  tcw_state_t        state_r, state_nxt;
  tcw_in_t           req_r, req_nxt;
  logic [7:0]        col_r, col_nxt, row_r, row_nxt;
  logic [CPOS_W-1:0] cpos_r, cpos_nxt, ws_r, ws_nxt, shown_r, shown_nxt;
  logic [15:0]       lc_r, lc_nxt, l1c_r, l1c_nxt;
  logic              lf_cr_r, lf_cr_nxt;
  logic [15:0]       wr_data_r, wr_data_nxt;
  logic              wr_adv_r, wr_adv_nxt;
  logic [15:0]       cp_rd_r, cp_rd_nxt;
  logic              cp_pend_r, cp_pend_nxt;
  logic [ADDR_W-1:0] cp_dst_r, cp_dst_nxt;
  logic              cp_fwd_r, cp_fwd_nxt;
  logic [15:0]       cp_fwd_data_r, cp_fwd_data_nxt;
  logic [CPOS_W-1:0] bl_base_r, bl_base_nxt;
  logic [7:0]        bl_cnt_r, bl_cnt_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [7:0]        tc_r, tc_nxt, tr_r, tr_nxt;
  logic [15:0]       prod_r, prod_nxt;
  logic              ok_r, ok_nxt;
  logic [15:0]       cell_r, cell_nxt;
  logic              out_valid_r, out_valid_nxt;
  tcw_out_t          out_res_r, out_res_nxt;

  logic [7:0]        cols_e, lines_e, chr;
  logic [16:0]       term_e;
  logic [CPOS_W-1:0] cols_x, ws_inc, end_pos, cp_src, bl_pos, place_pos, idx_ext;
  logic [15:0]       cp_wdata;
  logic              cp_issue;

  // Zero geometry acts as one; the window is clamped to the store
  assign cols_e  = (cfg.num_columns == 8'd0) ? 8'd1 : cfg.num_columns;
  assign lines_e = (cfg.num_lines == 8'd0) ? 8'd1 : cfg.num_lines;
  assign term_e  = (cfg.window_words == 15'd0)     ? 17'd1 :
                   (17'(cfg.window_words) > VW_L)  ? VW_L  : 17'(cfg.window_words);
  assign cols_x  = CPOS_W'(cols_e);
  assign chr     = req_r.char_code;

  assign ws_inc    = ws_r + cols_x;
  assign end_pos   = ws_inc + CPOS_W'(lc_r);
  assign cp_src    = ws_r + CPOS_W'(cp_rd_r);
  assign cp_issue  = (cp_rd_r < l1c_r);
  assign cp_wdata  = cp_fwd_r ? cp_fwd_data_r : mem_rdata;
  assign bl_pos    = bl_base_r + CPOS_W'(bl_cnt_r);
  assign place_pos = ws_r + CPOS_W'(prod_r) + CPOS_W'(tc_r);
  assign idx_ext   = CPOS_W'(req_r.cell_index);

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      cpos_r      <= '0;
      ws_r        <= '0;
      shown_r     <= '0;
      clr_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      cpos_r      <= cpos_nxt;
      ws_r        <= ws_nxt;
      shown_r     <= shown_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    lc_r          <= lc_nxt;
    l1c_r         <= l1c_nxt;
    lf_cr_r       <= lf_cr_nxt;
    wr_data_r     <= wr_data_nxt;
    wr_adv_r      <= wr_adv_nxt;
    cp_rd_r       <= cp_rd_nxt;
    cp_pend_r     <= cp_pend_nxt;
    cp_dst_r      <= cp_dst_nxt;
    cp_fwd_r      <= cp_fwd_nxt;
    cp_fwd_data_r <= cp_fwd_data_nxt;
    bl_base_r     <= bl_base_nxt;
    bl_cnt_r      <= bl_cnt_nxt;
    tc_r          <= tc_nxt;
    tr_r          <= tr_nxt;
    prod_r        <= prod_nxt;
    ok_r          <= ok_nxt;
    cell_r        <= cell_nxt;
    out_res_r     <= out_res_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    cpos_nxt        = cpos_r;
    ws_nxt          = ws_r;
    shown_nxt       = shown_r;
    lc_nxt          = lc_r;
    l1c_nxt         = l1c_r;
    lf_cr_nxt       = lf_cr_r;
    wr_data_nxt     = wr_data_r;
    wr_adv_nxt      = wr_adv_r;
    cp_rd_nxt       = cp_rd_r;
    cp_pend_nxt     = cp_pend_r;
    cp_dst_nxt      = cp_dst_r;
    cp_fwd_nxt      = cp_fwd_r;
    cp_fwd_data_nxt = cp_fwd_data_r;
    bl_base_nxt     = bl_base_r;
    bl_cnt_nxt      = bl_cnt_r;
    clr_cnt_nxt     = clr_cnt_r;
    tc_nxt          = tc_r;
    tr_nxt          = tr_r;
    prod_nxt        = prod_r;
    ok_nxt          = ok_r;
    cell_nxt        = cell_r;
    out_valid_nxt   = 1'b0;
    out_res_nxt     = out_res_r;
    mem_we          = 1'b0;
    mem_waddr       = cpos_r[ADDR_W-1:0];
    mem_wdata       = wr_data_r;
    mem_raddr       = cp_src[ADDR_W-1:0];

    case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == LAST_ADR) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          state_nxt = ST_PREP;
        end
      end

      ST_PREP: begin
        lc_nxt  = 16'(lines_e) * 16'(cols_e);
        l1c_nxt = 16'(lines_e - 8'd1) * 16'(cols_e);
        case (req_r.req_type)
          REQ_READ: begin
            mem_raddr = idx_ext[ADDR_W-1:0];
            state_nxt = ST_RDWAIT;
          end
          REQ_MOVE: state_nxt = ST_PMUL;
          REQ_PUT: begin
            if (chr >= CH_PRINT_LO && chr <= CH_PRINT_HI) begin
              wr_data_nxt = {cfg.text_attr, chr};
              wr_adv_nxt  = 1'b1;
              // Lazy wrap: the pending line feed is taken now
              if (col_r >= cols_e) begin
                col_nxt   = col_r - cols_e;
                cpos_nxt  = cpos_r - cols_x;
                lf_cr_nxt = 1'b0;
                state_nxt = ST_LF;
              end else begin
                state_nxt = ST_WRITE;
              end
            end else if (chr == CH_LF || chr == CH_VT || chr == CH_FF) begin
              lf_cr_nxt = 1'b1;
              state_nxt = ST_LF;
            end else if (chr == CH_CR) begin
              cpos_nxt  = cpos_r - CPOS_W'(col_r);
              col_nxt   = '0;
              state_nxt = ST_POST;
            end else if (chr == CH_DEL && col_r != 8'd0) begin
              cpos_nxt    = cpos_r - CPOS_W'(1);
              col_nxt     = col_r - 8'd1;
              wr_data_nxt = cfg.erase_cell;
              wr_adv_nxt  = 1'b0;
              state_nxt   = ST_WRITE;
            end else if (chr == CH_BS && col_r != 8'd0) begin
              cpos_nxt  = cpos_r - CPOS_W'(1);
              col_nxt   = col_r - 8'd1;
              state_nxt = ST_POST;
            end else begin
              state_nxt = ST_POST;
            end
          end
          default: state_nxt = ST_DONE;
        endcase
      end

      ST_LF: begin
        cpos_nxt = cpos_r + cols_x;
        if ((9'(row_r) + 9'd1) < 9'(lines_e)) begin
          row_nxt   = row_r + 8'd1;
          state_nxt = ST_LFEND;
        end else begin
          ws_nxt = ws_inc;
          if (end_pos > CPOS_W'(term_e)) begin
            cp_rd_nxt   = '0;
            cp_pend_nxt = 1'b0;
            cp_fwd_nxt  = 1'b0;
            state_nxt   = ST_COPY;
          end else begin
            bl_base_nxt = ws_inc + CPOS_W'(l1c_r);
            bl_cnt_nxt  = '0;
            state_nxt   = ST_BLANK;
          end
        end
      end

      ST_COPY: begin
        // Read one word ahead; forward a word that is written as it is read
        if (cp_pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = cp_dst_r;
          mem_wdata = cp_wdata;
        end
        cp_fwd_nxt      = cp_pend_r && (cp_src[ADDR_W-1:0] == cp_dst_r);
        cp_fwd_data_nxt = cp_wdata;
        cp_pend_nxt     = cp_issue;
        cp_dst_nxt      = cp_rd_r[ADDR_W-1:0];
        cp_rd_nxt       = cp_rd_r + 16'(cp_issue);
        if (!cp_issue && !cp_pend_r) begin
          cpos_nxt    = cpos_r - ws_r;
          ws_nxt      = '0;
          bl_base_nxt = CPOS_W'(l1c_r);
          bl_cnt_nxt  = '0;
          state_nxt   = ST_BLANK;
        end
      end

      ST_BLANK: begin
        mem_we     = 1'b1;
        mem_waddr  = bl_pos[ADDR_W-1:0];
        mem_wdata  = cfg.erase_cell;
        bl_cnt_nxt = bl_cnt_r + 8'd1;
        if (bl_cnt_r == cols_e - 8'd1) begin
          state_nxt = ST_LFEND;
        end
      end

      ST_LFEND: begin
        if (lf_cr_r) begin
          cpos_nxt  = cpos_r - CPOS_W'(col_r);
          col_nxt   = '0;
          state_nxt = ST_POST;
        end else begin
          state_nxt = ST_WRITE;
        end
      end

      ST_WRITE: begin
        mem_we = 1'b1;
        if (wr_adv_r) begin
          cpos_nxt = cpos_r + CPOS_W'(1);
          col_nxt  = col_r + 8'd1;
        end
        state_nxt = ST_POST;
      end

      ST_POST: begin
        state_nxt = req_r.end_of_text ? ST_PMUL : ST_DONE;
      end

      ST_PMUL: begin
        if (req_r.req_type == REQ_MOVE) begin
          tc_nxt   = req_r.new_col;
          tr_nxt   = req_r.new_row;
          prod_nxt = 16'(req_r.new_row) * 16'(cols_e);
          ok_nxt   = (req_r.new_col <= cols_e) && (req_r.new_row < lines_e);
        end else begin
          tc_nxt   = col_r;
          tr_nxt   = row_r;
          prod_nxt = 16'(row_r) * 16'(cols_e);
          ok_nxt   = (col_r <= cols_e) && (row_r < lines_e);
        end
        state_nxt = ST_PLACE;
      end

      ST_PLACE: begin
        if (ok_r) begin
          col_nxt   = tc_r;
          row_nxt   = tr_r;
          cpos_nxt  = place_pos;
          shown_nxt = place_pos;
        end else begin
          shown_nxt = cpos_r;
        end
        state_nxt = ST_DONE;
      end

      ST_RDWAIT: begin
        cell_nxt  = mem_rdata;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        out_valid_nxt             = 1'b1;
        out_res_nxt.read_cell     = (req_r.req_type == REQ_READ) ? cell_r : 16'd0;
        out_res_nxt.cursor_offset = shown_r[14:0];
        out_res_nxt.origin_offset = ws_r[13:0];
        out_res_nxt.cursor_col    = col_r;
        out_res_nxt.cursor_row    = row_r;
        state_nxt                 = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/text_console_writer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text-mode console engine over a character-cell store.
// ----------------------------------------------------------------------------
// One request is taken while busy is low; its result beat appears on out_res
// for a single cycle under out_valid and must be taken then, as the receiver
// cannot stall. After reset the store is swept to zero, one cell a cycle,
// with busy high until the sweep is done. End of text adds the cursor multiply
// and the cursor placement to a request. A line feed at the bottom row blanks
// one row; when the window runs past window_words the visible rows are first
// copied to address 0 through the store's read port and its write port. The
// user must keep VIDEO_WORDS a power of two; the block itself does not enforce
// it. Addresses wrap at VIDEO_WORDS.
// ----------------------------------------------------------------------------
module text_console_writer_top #(
  parameter int VIDEO_WORDS = tcw_pkg::TCW_VIDEO_WORDS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire tcw_pkg::tcw_in_t                in_req,
  output logic                                 out_valid,
  output tcw_pkg::tcw_out_t                    out_res,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tcw_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready
);
  import tcw_pkg::*;

  localparam int ADDR_W = $clog2(VIDEO_WORDS);

  tcw_cfg_t          cfg;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [15:0]       mem_wdata, mem_rdata;

  tcw_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcw_store #(.DEPTH(VIDEO_WORDS)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tcw_engine #(.VIDEO_WORDS(VIDEO_WORDS)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .start     (start),
    .in_req    (in_req),
    .busy      (busy),
    .out_valid (out_valid),
    .out_res   (out_res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // A taken request holds the engine until its result beat is issued
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request taken but engine not busy");

  a_beat_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without work behind it");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beat repeated");

endmodule
`default_nettype wire

FILE: tb/tb_text_console_writer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_console_writer_top
// Self-checking bench for the text console writer. A queue of requests
// feeds a clocked driver. A shadow of the cell store and cursor predicts each
// result beat at acceptance. A monitor checks every beat against the oldest
// prediction. Phases sweep the register settings, extremes among them, with
// the sender idling at different rates.
// ----------------------------------------------------------------------------
module tb_text_console_writer_top;
  import tcw_pkg::*;

  localparam int CELLS       = TCW_VIDEO_WORDS;
  localparam int QUIET_LIMIT = 300000;
  localparam int TAIL_CYCLES = 32;

  logic                  clk     = 1'b0;
  logic                  rst_n   = 1'b0;
  logic                  start   = 1'b0;
  tcw_in_t               in_req  = '0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [31:0]           pwdata  = '0;
  logic                  busy;
  logic                  out_valid;
  tcw_out_t              out_res;
  logic [31:0]           prdata;
  logic                  pready;

  text_console_writer_top #(.VIDEO_WORDS(CELLS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the console: cell store, cursor, window origin and registers
  logic [15:0] shadow_cells [CELLS];
  tcw_cfg_t    shadow_cfg;
  int unsigned cur_col, cur_row, cur_pos, origin, shown_pos;

  tcw_in_t     pending_reqs [$];
  tcw_out_t    due_results [$];
  tcw_out_t    want_res;

  int unsigned idle_pct = 0;
  int unsigned faults = 0;
  int unsigned quiet_cycles = 0;
  int unsigned accepted = 0;
  int unsigned settings_used = 0;
  int unsigned puts = 0, reads = 0, moves = 0, scrolls = 0, rebases = 0;

  function automatic int unsigned eff_cols();
    return (shadow_cfg.num_columns == 8'd0) ? 1 : int'(shadow_cfg.num_columns);
  endfunction

  function automatic int unsigned eff_lines();
    return (shadow_cfg.num_lines == 8'd0) ? 1 : int'(shadow_cfg.num_lines);
  endfunction

  function automatic int unsigned eff_window();
    if (shadow_cfg.window_words == 15'd0) return 1;
    if (int'(shadow_cfg.window_words) > CELLS) return CELLS;
    return int'(shadow_cfg.window_words);
  endfunction

  function automatic void blank_cells(int unsigned at);
    for (int unsigned i = 0; i < eff_cols(); i++) begin
      shadow_cells[(at + i) % CELLS] = shadow_cfg.erase_cell;
    end
  endfunction

  function automatic void next_line();
    int unsigned cols, lines, last, span;
    cols  = eff_cols();
    lines = eff_lines();
    if (cur_row + 1 < lines) begin
      cur_row++;
      cur_pos += cols;
    end else begin
      scrolls++;
      origin  += cols;
      cur_pos += cols;
      last = origin + lines * cols;
      if (last > eff_window()) begin
        // copy the visible rows down to address 0, oldest word first
        span = (lines - 1) * cols;
        for (int unsigned i = 0; i < span; i++) begin
          shadow_cells[i % CELLS] = shadow_cells[(origin + i) % CELLS];
        end
        blank_cells(span);
        cur_pos -= origin;
        origin = 0;
        rebases++;
      end else begin
        blank_cells(last - cols);
      end
    end
  endfunction

  function automatic void place_at(int unsigned c, int unsigned r);
    if (c > eff_cols() || r >= eff_lines()) return;
    cur_col = c;
    cur_row = r;
    cur_pos = origin + r * eff_cols() + c;
  endfunction

  function automatic tcw_out_t console_step(tcw_in_t rq);
    tcw_out_t    res;
    logic [7:0]  ch;
    logic [15:0] rd_word;
    ch      = rq.char_code;
    rd_word = '0;
    case (rq.req_type)
      REQ_PUT: begin
        puts++;
        if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
          // lazy wrap: only a printable byte past the edge moves down
          if (cur_col >= eff_cols()) begin
            cur_col -= eff_cols();
            cur_pos -= eff_cols();
            next_line();
          end
          shadow_cells[cur_pos % CELLS] = {shadow_cfg.text_attr, ch};
          cur_pos++;
          cur_col++;
        end else if (ch == CH_LF || ch == CH_VT || ch == CH_FF) begin
          next_line();
          cur_pos -= cur_col;
          cur_col = 0;
        end else if (ch == CH_CR) begin
          cur_pos -= cur_col;
          cur_col = 0;
        end else if (ch == CH_DEL) begin
          if (cur_col != 0) begin
            cur_pos--;
            cur_col--;
            shadow_cells[cur_pos % CELLS] = shadow_cfg.erase_cell;
          end
        end else if (ch == CH_BS) begin
          if (cur_col != 0) begin
            cur_col--;
            cur_pos--;
          end
        end
        if (rq.end_of_text) begin
          place_at(cur_col, cur_row);
          shown_pos = cur_pos;
        end
      end
      REQ_READ: begin
        reads++;
        rd_word = shadow_cells[rq.cell_index];
      end
      REQ_MOVE: begin
        moves++;
        place_at(rq.new_col, rq.new_row);
        shown_pos = cur_pos;
      end
      default: ;
    endcase
    res.read_cell     = rd_word;
    res.cursor_offset = 15'(shown_pos);
    res.origin_offset = 14'(origin);
    res.cursor_col    = 8'(cur_col);
    res.cursor_row    = 8'(cur_row);
    return res;
  endfunction

  function automatic tcw_in_t cmd(tcw_req_t req, logic [7:0] ch, logic eot,
                                  logic [13:0] idx, logic [7:0] col, logic [7:0] row);
    tcw_in_t it;
    it.req_type    = req;
    it.char_code   = ch;
    it.end_of_text = eot;
    it.cell_index  = idx;
    it.new_col     = col;
    it.new_row     = row;
    return it;
  endfunction

  // Mostly printables and control bytes, with reads, moves and some noise
  function automatic tcw_in_t make_item(int unsigned lf_pct);
    tcw_in_t     it;
    int unsigned pick;
    it.req_type    = REQ_PUT;
    it.char_code   = 8'($urandom);
    it.end_of_text = ($urandom_range(99) < 30);
    it.cell_index  = $urandom_range(1) ? 14'($urandom) : 14'($urandom_range(600));
    it.new_col     = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(eff_cols() + 1));
    it.new_row     = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(eff_lines()));
    pick = $urandom_range(99);
    if (pick < lf_pct) begin
      pick = $urandom_range(2);
      it.char_code = (pick == 0) ? CH_LF : (pick == 1) ? CH_VT : CH_FF;
    end else begin
      pick = $urandom_range(99);
      if (pick < 52)      it.char_code = 8'($urandom_range(CH_PRINT_HI, CH_PRINT_LO));
      else if (pick < 58) it.char_code = CH_CR;
      else if (pick < 63) it.char_code = CH_BS;
      else if (pick < 68) it.char_code = CH_DEL;
      else if (pick < 73) it.char_code = $urandom_range(1) ? 8'($urandom_range(255, 128))
                                                           : 8'($urandom_range(31, 14));
      else if (pick < 86) it.req_type = REQ_READ;
      else if (pick < 96) it.req_type = REQ_MOVE;
      else                it.req_type = REQ_NONE;
    end
    return it;
  endfunction

  // Driver: predict on each accepted beat, then offer the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        due_results.push_back(console_step(in_req));
        accepted++;
      end
      if (!start || !busy) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_req <= pending_reqs.pop_front();
          start  <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: a result beat lasts one cycle and cannot be held off
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected result beat: cell %h cur %0d org %0d col %0d row %0d",
                   out_res.read_cell, out_res.cursor_offset, out_res.origin_offset,
                   out_res.cursor_col, out_res.cursor_row);
      end else begin
        want_res = due_results.pop_front();
        if (out_res.read_cell !== want_res.read_cell ||
            out_res.cursor_offset !== want_res.cursor_offset ||
            out_res.origin_offset !== want_res.origin_offset ||
            out_res.cursor_col !== want_res.cursor_col ||
            out_res.cursor_row !== want_res.cursor_row) begin
          faults++;
          if (faults <= 10)
            $display({"mismatch at %0t: expected cell %h cur %0d org %0d col %0d row %0d,",
                      " got cell %h cur %0d org %0d col %0d row %0d"},
                     $realtime, want_res.read_cell, want_res.cursor_offset,
                     want_res.origin_offset, want_res.cursor_col, want_res.cursor_row,
                     out_res.read_cell, out_res.cursor_offset, out_res.origin_offset,
                     out_res.cursor_col, out_res.cursor_row);
        end
      end
    end
  end

  // Watchdog: nothing accepted on either side for too long ends the run
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("text_console_writer_top test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || due_results.size() != 0 || start || busy);
  endtask

  task automatic write_reg(tcw_reg_t idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    // register takes the value at this edge
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_NUM_COLUMNS:  shadow_cfg.num_columns  = value[7:0];
      REG_NUM_LINES:    shadow_cfg.num_lines    = value[7:0];
      REG_WINDOW_WORDS: shadow_cfg.window_words = value[14:0];
      REG_ERASE_CELL:   shadow_cfg.erase_cell   = value[15:0];
      REG_TEXT_ATTR:    shadow_cfg.text_attr    = value[7:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(logic [7:0] cols, logic [7:0] lines, logic [14:0] words,
                           logic [15:0] blank, logic [7:0] attr, int unsigned feeds,
                           int unsigned count, int unsigned lf_pct, int unsigned idle);
    write_reg(REG_NUM_COLUMNS, 32'(cols));
    write_reg(REG_NUM_LINES, 32'(lines));
    write_reg(REG_WINDOW_WORDS, 32'(words));
    write_reg(REG_ERASE_CELL, 32'(blank));
    write_reg(REG_TEXT_ATTR, 32'(attr));
    settings_used++;
    idle_pct = idle;
    repeat (feeds) pending_reqs.push_back(cmd(REQ_PUT, CH_LF, 1'b0, 14'($urandom),
                                              8'($urandom), 8'($urandom)));
    repeat (count) pending_reqs.push_back(make_item(lf_pct));
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) shadow_cells[i] = '0;
    shadow_cfg = {RST_NUM_COLUMNS, RST_NUM_LINES, RST_WINDOW_WORDS,
                  RST_ERASE_CELL, RST_TEXT_ATTR};
    cur_col = 0;
    cur_row = 0;
    cur_pos = 0;
    origin = 0;
    shown_pos = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // hold off until the store sweep after reset has finished
    wait_idle();

    // Directed requests at the reset settings
    settings_used++;
    pending_reqs.push_back(cmd(REQ_READ, 8'd0, 1'b0, 14'd0, 8'd0, 8'd0));
    pending_reqs.push_back(cmd(REQ_READ, 8'd0, 1'b0, 14'h3fff, 8'd0, 8'd0));
    pending_reqs.push_back(cmd(REQ_PUT, "A", 1'b0, 14'd0, 8'd0, 8'd0));
    pending_reqs.push_back(cmd(REQ_PUT, CH_PRINT_LO, 1'b0, 14'd0, 8'd0, 8'd0));
    pending_reqs.push_back(cmd(REQ_PUT, CH_PRINT_HI, 1'b1, 14'd0, 8'd0, 8'd0));
    pending_reqs.push_back(cmd(REQ_PUT, 8'd0, 1'b0, 14'h3fff, 8'hff, 8'hff));
    pending_reqs.push_back(cmd(REQ_PUT, 8'd9, 1'b0, 14'd0, 8'd0, 8'd0));
    pending_reqs.push_back(cmd(REQ_PUT, 8'd31, 1'b0, 14'd0, 8'd0, 8'd0));
    pending_reqs.push_back(cmd(REQ_PUT, 8'd128, 1'b0, 14'd0, 8'd0, 8'd0));
    pending_reqs.push_back(cmd(REQ_PUT, 8'd255, 1'b1, 14'd0, 8'd0, 8'd0));
    pending_reqs.push_back(cmd(REQ_PUT, CH_BS, 1'b0, 14'd0, 8'd0, 8'd0));
    pending_reqs.push_back(cmd(REQ_PUT, CH_DEL, 1'b1, 14'd0, 8'd0, 8'd0));
    pending_reqs.push_back(cmd(REQ_READ, 8'd0, 1'b0, 14'd1, 8'd0, 8'd0));
    pending_reqs.push_back(cmd(REQ_PUT, CH_CR, 1'b0, 14'd0, 8'd0, 8'd0));
    pending_reqs.push_back(cmd(REQ_PUT, CH_BS, 1'b0, 14'd0, 8'd0, 8'd0));
    pending_reqs.push_back(cmd(REQ_PUT, CH_DEL, 1'b1, 14'd0, 8'd0, 8'd0));
    pending_reqs.push_back(cmd(REQ_PUT, CH_LF, 1'b0, 14'd0, 8'd0, 8'd0));
    pending_reqs.push_back(cmd(REQ_PUT, CH_VT, 1'b0, 14'd0, 8'd0, 8'd0));
    pending_reqs.push_back(cmd(REQ_PUT, CH_FF, 1'b1, 14'd0, 8'd0, 8'd0));
    // park just past the right edge of the bottom row, then wrap into a scroll
    pending_reqs.push_back(cmd(REQ_MOVE, 8'd0, 1'b0, 14'd0, 8'd80, 8'd24));
    pending_reqs.push_back(cmd(REQ_PUT, "z", 1'b1, 14'd0, 8'd0, 8'd0));
    pending_reqs.push_back(cmd(REQ_MOVE, 8'd0, 1'b0, 14'd0, 8'd81, 8'd0));
    pending_reqs.push_back(cmd(REQ_MOVE, 8'd0, 1'b0, 14'd0, 8'd0, 8'd25));
    pending_reqs.push_back(cmd(REQ_MOVE, 8'd0, 1'b0, 14'd0, 8'hff, 8'hff));
    pending_reqs.push_back(cmd(REQ_NONE, "Q", 1'b1, 14'd0, 8'd0, 8'd0));
    wait_idle();
    idle_pct = 0;
    repeat (150) pending_reqs.push_back(make_item(8));
    wait_idle();

    //        cols    lines   window     erase       attr  feeds cnt  lf  idle
    run_phase(8'd8,   8'd4,   15'd64,    16'hffff,   8'hff, 0,  300, 15, 55);
    run_phase(8'd1,   8'd1,   15'd1,     16'h0000,   8'h00, 0,  150, 10, 36);
    run_phase(8'd0,   8'd0,   15'd0,     16'h1234,   8'h5a, 0,  100, 10, 0);
    run_phase(8'd13,  8'd5,   15'h7fff,  16'ha5c3,   8'h81, 0,  250, 10, 55);
    // march the origin up near the top of the store, one row per line feed
    run_phase(8'd255, 8'd1,   15'd16384, 16'h0720,   8'h07, 63, 60,  0,  0);
    // full-size screen from there: addresses wrap and a scroll copies it all
    run_phase(8'd255, 8'd255, 15'd16384, 16'h3c5a,   8'h70, 0,  40,  3,  0);
    run_phase(8'd40,  8'd10,  15'd450,   16'h0720,   8'h1e, 0,  300, 12, 36);
    run_phase(8'd6,   8'd3,   15'd10,    16'h5f2d,   8'hc3, 0,  250, 15, 55);
    run_phase(RST_NUM_COLUMNS, RST_NUM_LINES, RST_WINDOW_WORDS, RST_ERASE_CELL,
              RST_TEXT_ATTR, 0, 150, 5, 36);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("ran %0d requests over %0d register settings: %0d puts, %0d reads, %0d moves",
             accepted, settings_used, puts, reads, moves);
    $display("%0d scrolls, %0d of them rebasing the window to 0; %0d mismatches",
             scrolls, rebases, faults);
    if (faults == 0 && due_results.size() == 0) begin
      $display("text_console_writer_top test passed");
    end else begin
      $display("text_console_writer_top test failed");
    end
    $finish;
  end

endmodule
